@@ rtl/assert_macros.svh @@
// Assertion helpers for the pattern finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define MLPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MLPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mlpf_pkg.sv @@
package mlpf_pkg;

  localparam int CfgDataWidth = 28;
  localparam int MaskWidth    = 14;

  localparam logic [2:0] CNT_MAX     = 3'd7;
  localparam logic [2:0] QUAL_OFFSET = 3'd3;

  typedef enum logic [2:0] {
    CFG_COLLISION_MASK = 3'd0,
    CFG_DRIFT_TIME     = 3'd1,
    CFG_COLL_PRETRIG   = 3'd2,
    CFG_COLL_TRIG      = 3'd3,
    CFG_ACC_PRETRIG    = 3'd4,
    CFG_ACC_TRIG       = 3'd5,
    CFG_TRIGGER_MODE   = 3'd6,
    CFG_MIRROR         = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_BOTH      = 2'd0,
    MODE_KILL_COLL = 2'd1,
    MODE_KILL_ACC  = 2'd2,
    MODE_ACC_VETO  = 2'd3
  } trig_mode_t;

  typedef struct packed {
    logic [2*MaskWidth-1:0] collision_mask;
    logic [2:0]             drift_time;
    logic [2:0]             coll_pretrig;
    logic [2:0]             coll_trig;
    logic [2:0]             acc_pretrig_level;
    logic [2:0]             acc_trig_level;
    trig_mode_t             trigger_mode;
    logic                   mirror;
  } cfg_t;

  typedef struct packed {
    logic [2:0] l0;
    logic [1:0] l1;
    logic       l2;
    logic [1:0] l3;
    logic [2:0] l4;
    logic [2:0] l5;
  } hits_t;

  typedef struct packed {
    logic [2:0] coll_a;
    logic [2:0] coll_b;
    logic [2:0] acc;
  } counts_t;

  // Layer count minus the offset, floored at zero.
  function automatic logic [1:0] quality(input logic [2:0] n);
    logic [2:0] d;
    d = n - QUAL_OFFSET;
    return (n >= QUAL_OFFSET) ? d[1:0] : 2'd0;
  endfunction

endpackage

@@ rtl/mlpf_cfg_regs.sv @@
module mlpf_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [2:0]                         cfg_index,
  input  logic [mlpf_pkg::CfgDataWidth-1:0]  cfg_data,
  output mlpf_pkg::cfg_t                     cfg
);
  import mlpf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.collision_mask    <= '1;
      cfg.drift_time        <= 3'd0;
      cfg.coll_pretrig      <= 3'd2;
      cfg.coll_trig         <= 3'd4;
      cfg.acc_pretrig_level <= 3'd2;
      cfg.acc_trig_level    <= 3'd4;
      cfg.trigger_mode      <= MODE_BOTH;
      cfg.mirror            <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_COLLISION_MASK: cfg.collision_mask    <= cfg_data[2*MaskWidth-1:0];
        CFG_DRIFT_TIME:     cfg.drift_time        <= cfg_data[2:0];
        CFG_COLL_PRETRIG:   cfg.coll_pretrig      <= cfg_data[2:0];
        CFG_COLL_TRIG:      cfg.coll_trig         <= cfg_data[2:0];
        CFG_ACC_PRETRIG:    cfg.acc_pretrig_level <= cfg_data[2:0];
        CFG_ACC_TRIG:       cfg.acc_trig_level    <= cfg_data[2:0];
        CFG_TRIGGER_MODE:   cfg.trigger_mode      <= trig_mode_t'(cfg_data[1:0]);
        CFG_MIRROR:         cfg.mirror            <= cfg_data[0];
        default:            cfg.mirror            <= cfg.mirror;
      endcase
    end
  end

endmodule

@@ rtl/mlpf_layer_count.sv @@
module mlpf_layer_count (
  input  mlpf_pkg::hits_t                     hits,
  input  logic [2*mlpf_pkg::MaskWidth-1:0]    collision_mask,
  input  logic                                mirror,
  output mlpf_pkg::counts_t                   counts
);
  import mlpf_pkg::*;

  // A layer counts when any of its unmasked hit bits is set.
  function automatic logic [2:0] coll_count(input hits_t h, input logic [MaskWidth-1:0] m);
    logic [5:0] lay;
    lay[0] = |(h.l0 & m[2:0]);
    lay[1] = |(h.l1 & m[4:3]);
    lay[2] = h.l2 & m[5];
    lay[3] = |(h.l3 & m[7:6]);
    lay[4] = |(h.l4 & m[10:8]);
    lay[5] = |(h.l5 & m[13:11]);
    return {2'b0, lay[0]} + {2'b0, lay[1]} + {2'b0, lay[2]} +
           {2'b0, lay[3]} + {2'b0, lay[4]} + {2'b0, lay[5]};
  endfunction

  logic [5:0] acc_bits;

  always_comb begin
    if (mirror) begin
      acc_bits = {hits.l5[2], hits.l4[2], hits.l3[1], hits.l2, hits.l1[0], hits.l0[0]};
    end else begin
      acc_bits = {hits.l5[0], hits.l4[0], hits.l3[0], hits.l2, hits.l1[1], hits.l0[2]};
    end
  end

  assign counts.coll_a = coll_count(hits, collision_mask[MaskWidth-1:0]);
  assign counts.coll_b = coll_count(hits, collision_mask[2*MaskWidth-1:MaskWidth]);
  assign counts.acc    = {2'b0, acc_bits[0]} + {2'b0, acc_bits[1]} + {2'b0, acc_bits[2]} +
                         {2'b0, acc_bits[3]} + {2'b0, acc_bits[4]} + {2'b0, acc_bits[5]};

endmodule

@@ rtl/mlpf_crossing_ctr.sv @@
module mlpf_crossing_ctr (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [2:0] count,
  input  logic [2:0] pretrig,
  input  logic [2:0] trig,
  input  logic [2:0] drift_time,
  input  logic       kill,
  output logic       found,
  output logic [2:0] ctr
);
  import mlpf_pkg::*;

  logic [2:0] ctr_next;

  // The flag looks at the counter as it stood before this crossing.
  assign found = (ctr == drift_time) && (count >= trig);

  always_comb begin
    if ((count < pretrig) || kill) begin
      ctr_next = 3'd0;
    end else if (ctr == CNT_MAX) begin
      ctr_next = CNT_MAX;
    end else begin
      ctr_next = ctr + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr <= 3'd0;
    end else if (advance) begin
      ctr <= ctr_next;
    end
  end

endmodule

@@ rtl/muon_layer_pattern_finder.sv @@
// Muon layer pattern finder. Each request carries the hits of one bunch
// crossing on six detector layers and yields exactly one result: a quality
// and a valid flag for collision pattern A, collision pattern B and the
// accelerator pattern. The block is a two-register pipeline: the crossing is
// captured in an input register, the layer counts, counter compares and
// flags are formed in one short combinational step, and the result lands in
// an output register. It takes one request per clock cycle while the output
// is not stalled; a crossing moves on into the output register whenever that
// register is free. The three saturating crossing counters are updated in
// the same cycle that a crossing moves into the output register, which is
// what keeps the rate at one per cycle. When the output is stalled, one more
// request is still taken into the input register before in_stall rises.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and should only be changed while no request is in flight.
module muon_layer_pattern_finder (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [mlpf_pkg::CfgDataWidth-1:0] cfg_data,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        layer0_hits,
  input  logic [1:0]                        layer1_hits,
  input  logic                              layer2_hit,
  input  logic [1:0]                        layer3_hits,
  input  logic [2:0]                        layer4_hits,
  input  logic [2:0]                        layer5_hits,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        coll_a_quality,
  output logic                              coll_a_valid,
  output logic [1:0]                        coll_b_quality,
  output logic                              coll_b_valid,
  output logic [1:0]                        acc_quality,
  output logic                              acc_valid
);
  import mlpf_pkg::*;
  `include "assert_macros.svh"

  cfg_t       cfg;
  hits_t      s1_hits;
  logic       s1_valid;
  counts_t    counts;
  logic       out_free;
  logic       s1_move;
  logic       in_take;
  logic       found_a;
  logic       found_b;
  logic       found_acc;
  logic       veto;
  logic [2:0] ctr_a;
  logic [2:0] ctr_b;
  logic [2:0] ctr_acc;

  mlpf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The output register can take a new result when it is empty or when its
  // current result is being taken in this cycle.
  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_hits <= '{l0: layer0_hits, l1: layer1_hits, l2: layer2_hit,
                   l3: layer3_hits, l4: layer4_hits, l5: layer5_hits};
    end
  end

  mlpf_layer_count u_count (
    .hits           (s1_hits),
    .collision_mask (cfg.collision_mask),
    .mirror         (cfg.mirror),
    .counts         (counts)
  );

  // One counter per pattern; each advances exactly once per crossing, as
  // the crossing leaves the input register.
  mlpf_crossing_ctr u_ctr_a (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_move),
    .count      (counts.coll_a),
    .pretrig    (cfg.coll_pretrig),
    .trig       (cfg.coll_trig),
    .drift_time (cfg.drift_time),
    .kill       (cfg.trigger_mode == MODE_KILL_COLL),
    .found      (found_a),
    .ctr        (ctr_a)
  );

  mlpf_crossing_ctr u_ctr_b (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_move),
    .count      (counts.coll_b),
    .pretrig    (cfg.coll_pretrig),
    .trig       (cfg.coll_trig),
    .drift_time (cfg.drift_time),
    .kill       (cfg.trigger_mode == MODE_KILL_COLL),
    .found      (found_b),
    .ctr        (ctr_b)
  );

  mlpf_crossing_ctr u_ctr_acc (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_move),
    .count      (counts.acc),
    .pretrig    (cfg.acc_pretrig_level),
    .trig       (cfg.acc_trig_level),
    .drift_time (cfg.drift_time),
    .kill       (cfg.trigger_mode == MODE_KILL_ACC),
    .found      (found_acc),
    .ctr        (ctr_acc)
  );

  // In veto mode an accelerator track suppresses both collision flags; the
  // collision qualities and counters are left alone.
  assign veto = (cfg.trigger_mode == MODE_ACC_VETO) && found_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      coll_a_quality <= quality(counts.coll_a);
      coll_a_valid   <= found_a && !veto;
      coll_b_quality <= quality(counts.coll_b);
      coll_b_valid   <= found_b && !veto;
      acc_quality    <= quality(counts.acc);
      acc_valid      <= found_acc;
    end
  end

  `MLPF_ASSERT(a_stall_needs_item, in_stall |-> s1_valid, "input stalled with empty pipeline")
  `MLPF_ASSERT(a_move_fills_out, s1_move |=> out_valid, "crossing lost on its way to output")
  `MLPF_ASSERT(a_acc_ctr_step,
               (ctr_acc == 3'd0) || (ctr_acc == $past(ctr_acc)) ||
               (ctr_acc == $past(ctr_acc) + 3'd1),
               "accelerator crossing counter jumped")
  `MLPF_ASSERT(a_coll_ctr_hold,
               !$past(s1_move) |-> (ctr_a == $past(ctr_a)) && (ctr_b == $past(ctr_b)),
               "collision counter moved without a crossing")

endmodule

@@ dv/tb_muon_layer_pattern_finder.sv @@
`timescale 1ns / 100ps

// Testbench for the muon layer pattern finder.
//
// Every request carries one bunch crossing of hits and gives exactly one result.
// The bench keeps its own copy of the register settings and of the three
// crossing counters. At each accepted request it works out the expected result
// and queues it. Each accepted result is then compared field by field with the
// oldest entry in that queue.
//
// The run walks through several register settings, with the extremes among
// them. Registers are only written once the pipeline has drained. The first
// setting opens with a short table of hand-picked crossings. Every setting
// then gets a run of random crossings. These come in bursts (dense, sparse or
// pure noise) so that the crossing counters really climb to the drift time and
// the valid flags fire.
module tb_muon_layer_pattern_finder;
  import mlpf_pkg::*;

  localparam int NumSettings       = 8;
  localparam int CrossingsPerPhase = 50;
  localparam int LongHoldCycles    = 40;
  localparam int DrainCycles       = 4;   // idle margin after the queue empties, before any register write
  localparam int TimeoutNs         = 5_000_000;

  // One result as it appears on the output ports, in port order.
  typedef struct packed {
    logic [1:0] a_quality;
    logic       a_valid;
    logic [1:0] b_quality;
    logic       b_valid;
    logic [1:0] acc_quality;
    logic       acc_valid;
  } pattern_flags_t;

  // A row of the directed table. When pinned is set, the result is typed in by hand.
  typedef struct packed {
    hits_t          hits;
    logic           pinned;
    pattern_flags_t result;
  } directed_row_t;

  localparam int NumDirected = 14;

  // The first rows run at the reset settings: mask all ones, drift time 0, both
  // pretrigger levels 2, both trigger levels 4, mode "both", no mirror. The
  // counters start at 0, so a valid flag needs four or more layers. It also
  // needs the counter still at 0 when the crossing arrives.
  localparam directed_row_t DirectedRows [0:NumDirected-1] = '{
    // Empty crossing: nothing counts and the counters stay at zero.
    '{'{3'd0, 2'd0, 1'b0, 2'd0, 3'd0, 3'd0}, 1'b1, '{2'd0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0}},
    // Every hit bit set: six layers everywhere, all three patterns valid.
    '{'{3'd7, 2'd3, 1'b1, 2'd3, 3'd7, 3'd7}, 1'b1, '{2'd3, 1'b1, 2'd3, 1'b1, 2'd3, 1'b1}},
    // Same again. The counters are now at 1, past the drift time, so no flags.
    '{'{3'd7, 2'd3, 1'b1, 2'd3, 3'd7, 3'd7}, 1'b1, '{2'd3, 1'b0, 2'd3, 1'b0, 2'd3, 1'b0}},
    // Empty crossing clears all counters back to zero.
    '{'{3'd0, 2'd0, 1'b0, 2'd0, 3'd0, 3'd0}, 1'b1, '{2'd0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0}},
    // Only the mirrored accelerator bits are set. The unmirrored accelerator
    // pattern sees nothing, but five collision layers are hit.
    '{'{3'd1, 2'd1, 1'b0, 2'd2, 3'd4, 3'd4}, 1'b1, '{2'd2, 1'b1, 2'd2, 1'b1, 2'd0, 1'b0}},
    '{'{3'd0, 2'd0, 1'b0, 2'd0, 3'd0, 3'd0}, 1'b1, '{2'd0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0}},
    // Three layers: quality floors at zero, and three is below the trigger level.
    '{'{3'd4, 2'd2, 1'b1, 2'd0, 3'd0, 3'd0}, 1'b1, '{2'd0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0}},
    // The remaining rows mix single layers and bits with fuller crossings and leave the answer to the predictor.
    '{'{3'd4, 2'd2, 1'b1, 2'd1, 3'd1, 3'd1}, 1'b0, '0},
    '{'{3'd0, 2'd0, 1'b1, 2'd0, 3'd0, 3'd0}, 1'b0, '0},
    '{'{3'd1, 2'd0, 1'b0, 2'd0, 3'd0, 3'd0}, 1'b0, '0},
    '{'{3'd2, 2'd0, 1'b0, 2'd0, 3'd2, 3'd0}, 1'b0, '0},
    '{'{3'd0, 2'd0, 1'b0, 2'd0, 3'd0, 3'd7}, 1'b0, '0},
    '{'{3'd0, 2'd3, 1'b0, 2'd3, 3'd0, 3'd0}, 1'b0, '0},
    '{'{3'd7, 2'd3, 1'b1, 2'd3, 3'd7, 3'd7}, 1'b0, '0}
  };

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [2:0]              cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [2:0]              layer0_hits;
  logic [1:0]              layer1_hits;
  logic                    layer2_hit;
  logic [1:0]              layer3_hits;
  logic [2:0]              layer4_hits;
  logic [2:0]              layer5_hits;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              coll_a_quality;
  logic                    coll_a_valid;
  logic [1:0]              coll_b_quality;
  logic                    coll_b_valid;
  logic [1:0]              acc_quality;
  logic                    acc_valid;

  muon_layer_pattern_finder uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .layer0_hits    (layer0_hits),
    .layer1_hits    (layer1_hits),
    .layer2_hit     (layer2_hit),
    .layer3_hits    (layer3_hits),
    .layer4_hits    (layer4_hits),
    .layer5_hits    (layer5_hits),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .coll_a_quality (coll_a_quality),
    .coll_a_valid   (coll_a_valid),
    .coll_b_quality (coll_b_quality),
    .coll_b_valid   (coll_b_valid),
    .acc_quality    (acc_quality),
    .acc_valid      (acc_valid)
  );

  // Shadow of the block's registers and crossing counters.
  cfg_t    shadow_cfg;
  counts_t shadow_crossings;

  // Expected results, oldest first.
  pattern_flags_t pending_results [$];

  // Hand-typed answer that goes with the request currently on the input port.
  logic           pinned_row;
  pattern_flags_t pinned_result;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_request;

  int mismatches;
  int requests_accepted;
  int results_checked;
  int flagged_results;
  int vetoed_results;

  // State of the random burst generator.
  int burst_left;
  int burst_kind;

  always #10 clk = ~clk;

  // Prints one line for each failure and counts it.
  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_error($sformatf("result %0d: %s is %0d, expected %0d",
                             results_checked, name, got, want));
    end
  endtask

  // Number of layers that have at least one hit bit left after the 14-bit mask.
  function automatic logic [2:0] masked_layer_count(input hits_t h, input logic [13:0] m);
    logic [2:0] n;
    n = 3'(|(h.l0 & m[2:0])) + 3'(|(h.l1 & m[4:3])) + 3'(h.l2 & m[5])
      + 3'(|(h.l3 & m[7:6])) + 3'(|(h.l4 & m[10:8])) + 3'(|(h.l5 & m[13:11]));
    return n;
  endfunction

  function automatic logic [1:0] layer_quality(input logic [2:0] n);
    logic [2:0] above;
    above = n - QUAL_OFFSET;
    return (n >= QUAL_OFFSET) ? above[1:0] : 2'd0;
  endfunction

  function automatic logic [2:0] next_crossing_count(input logic [2:0] c, input logic clear);
    if (clear) return 3'd0;
    return (c == CNT_MAX) ? CNT_MAX : c + 3'd1;
  endfunction

  // Expected result for one crossing. The flags are formed from the counters
  // as they stood before this crossing, and only then are the counters advanced.
  function automatic pattern_flags_t evaluate_crossing(input hits_t h);
    logic [2:0]     n_a;
    logic [2:0]     n_b;
    logic [2:0]     n_acc;
    pattern_flags_t r;
    n_a = masked_layer_count(h, shadow_cfg.collision_mask[MaskWidth-1:0]);
    n_b = masked_layer_count(h, shadow_cfg.collision_mask[2*MaskWidth-1:MaskWidth]);
    if (shadow_cfg.mirror) begin
      n_acc = 3'(h.l0[0]) + 3'(h.l1[0]) + 3'(h.l2) + 3'(h.l3[1]) + 3'(h.l4[2]) + 3'(h.l5[2]);
    end else begin
      n_acc = 3'(h.l0[2]) + 3'(h.l1[1]) + 3'(h.l2) + 3'(h.l3[0]) + 3'(h.l4[0]) + 3'(h.l5[0]);
    end
    r.a_quality   = layer_quality(n_a);
    r.b_quality   = layer_quality(n_b);
    r.acc_quality = layer_quality(n_acc);
    r.acc_valid = (shadow_crossings.acc == shadow_cfg.drift_time)
                  && (n_acc >= shadow_cfg.acc_trig_level);
    r.a_valid = (shadow_crossings.coll_a == shadow_cfg.drift_time)
                && (n_a >= shadow_cfg.coll_trig);
    r.b_valid = (shadow_crossings.coll_b == shadow_cfg.drift_time)
                && (n_b >= shadow_cfg.coll_trig);
    // In veto mode an accelerator track kills both collision flags. The collision
    // qualities and counters are left alone.
    if (shadow_cfg.trigger_mode == MODE_ACC_VETO && r.acc_valid) begin
      r.a_valid = 1'b0;
      r.b_valid = 1'b0;
    end
    shadow_crossings.coll_a = next_crossing_count(shadow_crossings.coll_a,
        n_a < shadow_cfg.coll_pretrig || shadow_cfg.trigger_mode == MODE_KILL_COLL);
    shadow_crossings.coll_b = next_crossing_count(shadow_crossings.coll_b,
        n_b < shadow_cfg.coll_pretrig || shadow_cfg.trigger_mode == MODE_KILL_COLL);
    shadow_crossings.acc = next_crossing_count(shadow_crossings.acc,
        n_acc < shadow_cfg.acc_pretrig_level || shadow_cfg.trigger_mode == MODE_KILL_ACC);
    return r;
  endfunction

  // Random crossings come in bursts. Dense bursts set about seven bits in eight,
  // which keeps the counters climbing up to the drift time. Sparse bursts clear
  // the counters, and noise bursts give every bit an even chance.
  function automatic hits_t next_random_crossing();
    logic [13:0] bits;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      burst_kind = $urandom_range(99);
    end
    burst_left--;
    if (burst_kind < 55) begin
      bits = 14'($urandom | $urandom | $urandom);
    end else if (burst_kind < 75) begin
      bits = 14'($urandom & $urandom & $urandom);
    end else begin
      bits = 14'($urandom);
    end
    return bits;
  endfunction

  // The register values used in each phase. Phase 0 keeps the reset values.
  function automatic cfg_t phase_setting(input int phase);
    cfg_t s;
    s.collision_mask    = '1;
    s.drift_time        = 3'd0;
    s.coll_pretrig      = 3'd2;
    s.coll_trig         = 3'd4;
    s.acc_pretrig_level = 3'd2;
    s.acc_trig_level    = 3'd4;
    s.trigger_mode      = MODE_BOTH;
    s.mirror            = 1'b0;
    case (phase)
      1: begin
        // Empty mask and zero levels: the counters never clear, they saturate
        // and sit at the largest drift time.
        s.collision_mask    = '0;
        s.drift_time        = 3'd7;
        s.coll_pretrig      = 3'd0;
        s.coll_trig         = 3'd0;
        s.acc_pretrig_level = 3'd0;
        s.acc_trig_level    = 3'd0;
        s.mirror            = 1'b1;
      end
      2: begin
        s.collision_mask    = 28'($urandom);
        s.drift_time        = 3'd2;
        s.coll_pretrig      = 3'd3;
        s.coll_trig         = 3'd5;
        s.acc_pretrig_level = 3'd3;
        s.acc_trig_level    = 3'd5;
        s.trigger_mode      = MODE_ACC_VETO;
      end
      3: begin
        // Collision counters are held at zero, yet with drift time 0 the flags still fire.
        s.coll_pretrig      = 3'd7;
        s.coll_trig         = 3'd3;
        s.acc_pretrig_level = 3'd7;
        s.acc_trig_level    = 3'd3;
        s.trigger_mode      = MODE_KILL_COLL;
        s.mirror            = 1'b1;
      end
      4: begin
        s.collision_mask    = 28'h0003FFF;
        s.drift_time        = 3'd1;
        s.coll_pretrig      = 3'd1;
        s.coll_trig         = 3'd3;
        s.acc_pretrig_level = 3'd1;
        s.acc_trig_level    = 3'd3;
        s.trigger_mode      = MODE_KILL_ACC;
      end
      5: begin
        // Low trigger levels at drift time 0 make the accelerator veto frequent.
        s.collision_mask    = 28'hFFFC000;
        s.coll_trig         = 3'd2;
        s.acc_trig_level    = 3'd2;
        s.trigger_mode      = MODE_ACC_VETO;
        s.mirror            = 1'b1;
      end
      6: begin
        s.collision_mask    = 28'($urandom);
        s.drift_time        = 3'd3;
      end
      7: begin
        s.collision_mask    = 28'($urandom);
        s.drift_time        = 3'($urandom_range(7));
        s.coll_pretrig      = 3'($urandom_range(7));
        s.coll_trig         = 3'($urandom_range(7));
        s.acc_pretrig_level = 3'($urandom_range(7));
        s.acc_trig_level    = 3'($urandom_range(7));
        s.trigger_mode      = trig_mode_t'(2'($urandom_range(3)));
        s.mirror            = 1'($urandom_range(1));
      end
      default: ;
    endcase
    return s;
  endfunction

  // One register write. The shadow copy follows at the same clock edge.
  task automatic write_register(input cfg_index_t idx, input logic [CfgDataWidth-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_COLLISION_MASK: shadow_cfg.collision_mask    = value;
      CFG_DRIFT_TIME:     shadow_cfg.drift_time        = value[2:0];
      CFG_COLL_PRETRIG:   shadow_cfg.coll_pretrig      = value[2:0];
      CFG_COLL_TRIG:      shadow_cfg.coll_trig         = value[2:0];
      CFG_ACC_PRETRIG:    shadow_cfg.acc_pretrig_level = value[2:0];
      CFG_ACC_TRIG:       shadow_cfg.acc_trig_level    = value[2:0];
      CFG_TRIGGER_MODE:   shadow_cfg.trigger_mode      = trig_mode_t'(value[1:0]);
      CFG_MIRROR:         shadow_cfg.mirror            = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input cfg_t s);
    write_register(CFG_COLLISION_MASK, s.collision_mask);
    write_register(CFG_DRIFT_TIME, CfgDataWidth'(s.drift_time));
    write_register(CFG_COLL_PRETRIG, CfgDataWidth'(s.coll_pretrig));
    write_register(CFG_COLL_TRIG, CfgDataWidth'(s.coll_trig));
    write_register(CFG_ACC_PRETRIG, CfgDataWidth'(s.acc_pretrig_level));
    write_register(CFG_ACC_TRIG, CfgDataWidth'(s.acc_trig_level));
    write_register(CFG_TRIGGER_MODE, CfgDataWidth'(s.trigger_mode));
    write_register(CFG_MIRROR, CfgDataWidth'(s.mirror));
  endtask

  // Offers one crossing after a random gap and holds it steady until the block
  // takes it. Valid stays high from one request to the next unless a gap is drawn.
  task automatic send_crossing(input hits_t h, input logic pin, input pattern_flags_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    layer0_hits   <= h.l0;
    layer1_hits   <= h.l1;
    layer2_hit    <= h.l2;
    layer3_hits   <= h.l3;
    layer4_hits   <= h.l4;
    layer5_hits   <= h.l5;
    pinned_row    <= pin;
    pinned_result <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every queued result has come back. Then it
  // waits out the DrainCycles margin before any register is touched.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Receiver: drops stall requests at random. On request it holds off for a
  // long stretch, so that the pipeline fills up and in_stall has to rise.
  initial begin : receiver
    int held;
    held      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        out_stall <= 1'b1;
        held++;
        if (held == LongHoldCycles) begin
          hold_off_request = 1'b0;
          held = 0;
        end
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Both handshakes are sampled at the rising edge. An accepted request pushes
  // its expected result. An accepted result is checked against the oldest one.
  always @(posedge clk) begin : scoreboard
    pattern_flags_t predicted;
    pattern_flags_t seen;
    pattern_flags_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predicted = evaluate_crossing({layer0_hits, layer1_hits, layer2_hit,
                                       layer3_hits, layer4_hits, layer5_hits});
        requests_accepted++;
        pending_results.push_back(pinned_row ? pinned_result : predicted);
      end
      if (out_valid && !out_stall) begin
        seen = {coll_a_quality, coll_a_valid, coll_b_quality, coll_b_valid,
                acc_quality, acc_valid};
        results_checked++;
        if (seen.a_valid || seen.b_valid || seen.acc_valid) flagged_results++;
        if (pending_results.size() == 0) begin
          report_error($sformatf("result %0d arrived with no request pending",
                                 results_checked));
        end else begin
          want = pending_results.pop_front();
          if (shadow_cfg.trigger_mode == MODE_ACC_VETO && want.acc_valid) vetoed_results++;
          check_field("coll_a_quality", seen.a_quality, want.a_quality);
          check_field("coll_a_valid", seen.a_valid, want.a_valid);
          check_field("coll_b_quality", seen.b_quality, want.b_quality);
          check_field("coll_b_valid", seen.b_valid, want.b_valid);
          check_field("acc_quality", seen.acc_quality, want.acc_quality);
          check_field("acc_valid", seen.acc_valid, want.acc_valid);
        end
      end
    end
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("[%0t] timeout: %0d results still expected", $time, pending_results.size());
    $display("** muon_layer_pattern_finder: FAILED **");
    $finish;
  end

  initial begin : stimulus
    clk              = 1'b0;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CFG_COLLISION_MASK;
    cfg_data         = '0;
    in_valid         = 1'b0;
    layer0_hits      = '0;
    layer1_hits      = '0;
    layer2_hit       = 1'b0;
    layer3_hits      = '0;
    layer4_hits      = '0;
    layer5_hits      = '0;
    pinned_row       = 1'b0;
    pinned_result    = '0;
    hold_off_request = 1'b0;
    send_idle_pct    = 25;
    recv_idle_pct    = 51;
    burst_left       = 0;
    burst_kind       = 0;
    mismatches       = 0;
    requests_accepted = 0;
    results_checked  = 0;
    flagged_results  = 0;
    vetoed_results   = 0;
    shadow_cfg       = phase_setting(0);
    shadow_crossings = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < NumSettings; phase++) begin
      // Idle profile: the sender is the lighter idler in the first third, the
      // receiver in the second third, and nobody idles at the end.
      if (phase < 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 51;
      end else if (phase < 6) begin
        send_idle_pct = 51;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase != 0) begin
        drain_pipeline();
        apply_setting(phase_setting(phase));
      end
      // The long hold-off runs in phases 1 and 6; it is most telling when the sender never pauses.
      if (phase == 1 || phase == 6) hold_off_request = 1'b1;
      if (phase == 0) begin
        foreach (DirectedRows[i]) begin
          send_crossing(DirectedRows[i].hits, DirectedRows[i].pinned, DirectedRows[i].result);
        end
      end
      repeat (CrossingsPerPhase) send_crossing(next_random_crossing(), 1'b0, '0);
    end

    drain_pipeline();

    $display("Covered %0d register settings (all four modes, both mirror choices).",
             NumSettings);
    $display("%0d requests, %0d results checked, %0d with a valid flag, %0d vetoed.",
             requests_accepted, results_checked, flagged_results, vetoed_results);
    if (mismatches == 0) begin
      $display("** muon_layer_pattern_finder: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** muon_layer_pattern_finder: FAILED **");
    end
    $finish;
  end

endmodule
